@@ src/prc_pkg.sv @@
// shared types and constants for the page replacement core
`default_nettype none

package prc_pkg;

  // fixed field widths of the item and result ports
  localparam int PAGE_W = 3;
  localparam int FI_W   = 2;
  localparam int CNT_W  = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // replacement policy codes
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  // update command broadcast to every cell
  typedef struct packed {
    logic en;       // an item is being handled this cycle
    logic clear;    // empty all frames before the access
    logic load;     // target cell takes the new page
    logic age_all;  // every other valid cell ages by one
    logic age_lim;  // other valid cells younger than the limit age by one
  } prc_cmd_t;

  // flags rippling along the row of cells
  typedef struct packed {
    logic found;         // a cell further up matched the page
    logic victim_found;  // a cell further up holds the oldest rank
  } prc_chain_t;

endpackage

`default_nettype wire

@@ src/prc_cell.sv @@
// one frame cell: page, valid and age rank, with its link in the search chain
`default_nettype none

module prc_cell
  import prc_pkg::*;
#(
  parameter int FRAMES = 4,
  parameter int INDEX  = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [PAGE_W-1:0]         page_in,
  input  wire prc_cmd_t                  cmd,
  input  wire logic [$clog2(FRAMES)-1:0] target,
  input  wire logic [$clog2(FRAMES)-1:0] limit,
  input  wire prc_chain_t                chain_in,
  input  wire logic [$clog2(FRAMES)-1:0] hit_idx_in,
  input  wire logic [$clog2(FRAMES)-1:0] hit_rank_in,
  input  wire logic [$clog2(FRAMES)-1:0] vict_idx_in,
  input  wire logic [PAGE_W-1:0]         vict_page_in,
  output      prc_chain_t                chain_out,
  output      logic [$clog2(FRAMES)-1:0] hit_idx_out,
  output      logic [$clog2(FRAMES)-1:0] hit_rank_out,
  output      logic [$clog2(FRAMES)-1:0] vict_idx_out,
  output      logic [PAGE_W-1:0]         vict_page_out
);

  localparam int IW = $clog2(FRAMES);
  localparam logic [IW-1:0] MY_IDX   = IW'(INDEX);
  localparam logic [IW-1:0] OLDEST   = IW'(FRAMES - 1);

  logic [PAGE_W-1:0] page;
  logic              valid;
  logic [IW-1:0]     rank;

  logic [PAGE_W-1:0] page_next;
  logic              valid_next;
  logic [IW-1:0]     rank_next;

  logic          valid_eff;
  logic [IW-1:0] rank_eff;
  logic          match;
  logic          oldest;
  logic          is_target;

  assign valid_eff = valid & ~cmd.clear;
  assign rank_eff  = cmd.clear ? '0 : rank;
  assign match     = valid_eff && (page == page_in);
  assign oldest    = valid_eff && (rank_eff == OLDEST);
  assign is_target = (target == MY_IDX);

  // first match and first oldest frame win
  assign chain_out.found        = chain_in.found | match;
  assign chain_out.victim_found = chain_in.victim_found | oldest;
  assign hit_idx_out   = chain_in.found ? hit_idx_in  : MY_IDX;
  assign hit_rank_out  = chain_in.found ? hit_rank_in : rank_eff;
  assign vict_idx_out  = chain_in.victim_found ? vict_idx_in  : MY_IDX;
  assign vict_page_out = chain_in.victim_found ? vict_page_in : page;

  always_comb begin
    page_next  = page;
    valid_next = valid_eff;
    rank_next  = rank_eff;
    if (is_target && cmd.load) begin
      page_next  = page_in;
      valid_next = 1'b1;
      rank_next  = '0;
    end else if (is_target && cmd.age_lim) begin
      rank_next = '0;
    end else if (!is_target && valid_eff &&
                 (cmd.age_all || (cmd.age_lim && rank_eff < limit))) begin
      rank_next = rank_eff + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (cmd.en) begin
      valid <= valid_next;
      rank  <= rank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      page <= page_next;
    end
  end

endmodule

`default_nettype wire

@@ src/page_replacement_fifo_lru_core.sv @@
// top level of the fifo / lru page replacement core: row of frame cells and counters
//
//  channel  | signals                                 | handshake
//  ---------+-----------------------------------------+--------------------------------
//  item in  | page_number, start_over                 | taken when start && !busy
//  result   | hit, frame_index, evicted_valid,        | valid for one cycle with done
//           | evicted_page, fault_count, replace_count|
//  config   | cfg_wdata (policy_mode)                 | written when cfg_we
//
// one item per clock: busy never rises, and the result appears with done in the
// cycle after the item is taken. the figure is set by the row of frame cells,
// whose match and oldest-frame chain ripples combinationally through all FRAMES cells.
// rst clears all frames, both counters and the policy (fifo); page contents are
// left as they are, since a frame is only read once its valid bit is set.
// the receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module page_replacement_fifo_lru_core
  import prc_pkg::*;
#(
  parameter int FRAMES = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic [PAGE_W-1:0] page_number,
  input  wire logic              start_over,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  output      logic              done,
  output      logic              hit,
  output      logic [FI_W-1:0]   frame_index,
  output      logic              evicted_valid,
  output      logic [PAGE_W-1:0] evicted_page,
  output      logic [CNT_W-1:0]  fault_count,
  output      logic [CNT_W-1:0]  replace_count
);

  localparam int IW = $clog2(FRAMES);
  localparam int FW = $clog2(FRAMES + 1);
  localparam logic [FW-1:0] FULL_CNT = FW'(FRAMES);

  // configuration
  logic policy_mode;

  // fill count and saturating counters (the counters double as result ports)
  logic [FW-1:0] filled;
  logic [FW-1:0] filled_eff;
  logic [FW-1:0] filled_next;
  logic [CNT_W-1:0] faults_eff;
  logic [CNT_W-1:0] faults_next;
  logic [CNT_W-1:0] repl_eff;
  logic [CNT_W-1:0] repl_next;

  logic accept;
  logic full;
  logic hit_now;
  logic evict_now;
  logic [IW-1:0] target;

  prc_cmd_t cmd;

  // chain links, one more than the cell count
  prc_chain_t        chain     [FRAMES+1];
  logic [IW-1:0]     hit_idx   [FRAMES+1];
  logic [IW-1:0]     hit_rank  [FRAMES+1];
  logic [IW-1:0]     vict_idx  [FRAMES+1];
  logic [PAGE_W-1:0] vict_page [FRAMES+1];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // head of the chain: nothing found yet
  assign chain[0]     = '0;
  assign hit_idx[0]   = '0;
  assign hit_rank[0]  = '0;
  assign vict_idx[0]  = '0;
  assign vict_page[0] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < FRAMES; gi++) begin : g_cell
      prc_cell #(
        .FRAMES (FRAMES),
        .INDEX  (gi)
      ) u_cell (
        .clk           (clk),
        .rst           (rst),
        .page_in       (page_number),
        .cmd           (cmd),
        .target        (target),
        .limit         (hit_rank[FRAMES]),
        .chain_in      (chain[gi]),
        .hit_idx_in    (hit_idx[gi]),
        .hit_rank_in   (hit_rank[gi]),
        .vict_idx_in   (vict_idx[gi]),
        .vict_page_in  (vict_page[gi]),
        .chain_out     (chain[gi+1]),
        .hit_idx_out   (hit_idx[gi+1]),
        .hit_rank_out  (hit_rank[gi+1]),
        .vict_idx_out  (vict_idx[gi+1]),
        .vict_page_out (vict_page[gi+1])
      );
    end
  endgenerate

  // start over acts before the lookup
  assign filled_eff = start_over ? '0 : filled;
  assign faults_eff = start_over ? '0 : fault_count;
  assign repl_eff   = start_over ? '0 : replace_count;
  assign full       = (filled_eff == FULL_CNT);

  assign hit_now   = chain[FRAMES].found;
  assign evict_now = !hit_now && full;

  // hit keeps its frame; a miss fills the next free frame, or the oldest when full
  always_comb begin
    if (hit_now) begin
      target = hit_idx[FRAMES];
    end else if (full) begin
      target = vict_idx[FRAMES];
    end else begin
      target = filled_eff[IW-1:0];
    end
  end

  always_comb begin
    cmd.en      = accept;
    cmd.clear   = start_over;
    cmd.load    = !hit_now;
    cmd.age_all = !hit_now;
    cmd.age_lim = hit_now && (policy_mode == POLICY_LRU);
  end

  assign filled_next = (!hit_now && !full) ? filled_eff + 1'b1 : filled_eff;
  assign faults_next = (!hit_now && faults_eff != CNT_MAX) ? faults_eff + 1'b1 : faults_eff;
  assign repl_next   = (evict_now && repl_eff != CNT_MAX) ? repl_eff + 1'b1 : repl_eff;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode   <= POLICY_FIFO;
      filled        <= '0;
      fault_count   <= '0;
      replace_count <= '0;
      done          <= 1'b0;
    end else begin
      done <= accept;
      if (cfg_we) begin
        policy_mode <= cfg_wdata;
      end
      if (accept) begin
        filled        <= filled_next;
        fault_count   <= faults_next;
        replace_count <= repl_next;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      hit           <= hit_now;
      frame_index   <= FI_W'(target);
      evicted_valid <= evict_now;
      evicted_page  <= evict_now ? vict_page[FRAMES] : '0;
    end
  end

endmodule

`default_nettype wire
